[rtl/dres_pkg.sv]
`timescale 1ns / 1ps
// dres_pkg: shared types, codes and frame constants for the drive enable sequencer
// used by dres_rem_unit, dres_emitter and drive_enable_sequencer; no dependencies

package dres_pkg;

   // drive and timing constants
   localparam int unsigned MAX_DRIVES = 4;
   localparam logic [3:0] CMD_GAP_TICKS = 4'd5;
   localparam logic [3:0] ENABLE_GAP_TICKS = 4'd10;

   localparam int unsigned TIMER_W = 11;
   localparam int unsigned TICKS_W = 10;
   localparam int unsigned NODE_W = 7;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 80;

   typedef logic [1:0] drive_idx_type;
   typedef logic [MAX_DRIVES-1:0] drive_mask_type;
   typedef logic [MAX_DRIVES-1:0][NODE_W-1:0] node_ids_type;

   // input item kinds (carried in tuser)
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID_A = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID_B = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID_C = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID_D = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_PERIOD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_TIMEOUT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_HOLD = 3'd7;

   // supervisor phase, encoded as reported in control_state
   typedef enum logic [3:0] {
      PH_INIT      = 4'd0,
      PH_SYSCHECK  = 4'd1,
      PH_INITMOTOR = 4'd2,
      PH_CHECK     = 4'd3,
      PH_WAIT      = 4'd4,
      PH_BASE      = 4'd5,
      PH_FAULT     = 4'd6,
      PH_CLEAR     = 4'd7,
      PH_ERROR     = 4'd8
   } phase_type;

   // controlword commands
   localparam logic [7:0] CW_SHUTDOWN = 8'h06;
   localparam logic [7:0] CW_SWITCH_ON = 8'h07;
   localparam logic [7:0] CW_ENABLE_OP = 8'h0F;
   localparam logic [7:0] CW_FAULT_RESET = 8'h80;

   // can identifiers
   localparam logic [10:0] SDO_ID_BASE = 11'h600;
   localparam logic [3:0] TPDO_ID_HIGH = 4'b0011;

   // statusword decoding
   localparam logic [15:0] SW_OPEN_MASK = 16'h006F;
   localparam logic [15:0] SW_OPEN_VALUE = 16'h0027;
   localparam int unsigned SW_FAULT_BIT = 3;
   localparam int unsigned SW_ENABLED_BIT = 2;

   // sdo payloads, byte 0 in bits 7:0
   localparam logic [63:0] MODE_FRAME = 64'h0000_0003_0060_602F;
   localparam logic [63:0] CLEAR_AUX_FRAME = 64'h0000_0002_0620_102B;

   // kinds of frame runs the emitter produces
   typedef enum logic [2:0] {
      EK_NONE  = 3'd0,
      EK_MODE  = 3'd1,
      EK_CTRL  = 3'd2,
      EK_BURST = 3'd3,
      EK_CLEAR = 3'd4
   } emit_kind_type;

   typedef struct packed {
      emit_kind_type  kind;
      drive_mask_type mask;
      logic [7:0]     cmd;
      phase_type      state;
   } emit_cmd_type;

   // controlword sdo write to object 0x6040
   function automatic logic [63:0] ctrl_frame(input logic [7:0] cmd);
      return {24'h0, cmd, 32'h0060_402B};
   endfunction

   // init-motor step number to drive index
   function automatic drive_idx_type sub_drive(input logic [3:0] sub);
      drive_idx_type d;
      case (sub) inside
         [4'd2:4'd4]:   d = 2'd0;
         [4'd5:4'd7]:   d = 2'd1;
         [4'd8:4'd10]:  d = 2'd2;
         [4'd11:4'd13]: d = 2'd3;
         default:       d = 2'd0;
      endcase
      return d;
   endfunction

   // init-motor step number to command slot within the drive
   function automatic logic [1:0] sub_slot(input logic [3:0] sub);
      logic [1:0] k;
      case (sub) inside
         4'd2, 4'd5, 4'd8, 4'd11:  k = 2'd0;
         4'd3, 4'd6, 4'd9, 4'd12:  k = 2'd1;
         4'd4, 4'd7, 4'd10, 4'd13: k = 2'd2;
         default:                  k = 2'd0;
      endcase
      return k;
   endfunction

endpackage

[rtl/drive_enable_sequencer.sv]
`timescale 1ns / 1ps
// drive_enable_sequencer: top level, supervisor sequencer, status store and config
// depends on dres_pkg, dres_rem_unit and dres_emitter

// Supervises up to four CiA-402 drives. An input transaction with tuser high is a
// received CAN frame: a TPDO id 0x181..0x1FF matching a supervised node stores
// bytes 4-5 as that drive's statusword and yields one empty result. tuser low is a
// tick that advances the supervisor and yields its SDO frames (or one empty result),
// each tagged with the phase after the tick and tlast on the final one. One item at
// a time: results leave one per cycle out of the emitter's output register while
// rsp_tready is high; a tick in the wait phase first passes through the
// shift-subtract remainder unit that tests the retry period.
// Configuration writes are taken at any time but belong between transactions.

module drive_enable_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // input transactions
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // fields from bit 0: rx_id[10:0], rx_data[63:0], zero fill
   input  logic [dres_pkg::REQ_DATA_W-1:0]     req_tdata,
   // fields from bit 0: opcode
   input  logic                                req_tuser,
   // result transactions
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fields from bit 0: tx_valid, tx_id[10:0], tx_data[63:0], control_state[3:0]
   output logic [dres_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // configuration writes
   input  logic                                csr_we,
   input  logic [dres_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dres_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DIVIDE = 4'b0010,
      S_DECIDE = 4'b0100,
      S_EMIT   = 4'b1000
   } seq_state_type;

   // configuration registers
   logic [2:0]                         motor_count_ff;
   dres_pkg::node_ids_type             node_id_ff;
   logic [dres_pkg::TICKS_W-1:0]       retry_ff;
   logic [dres_pkg::TICKS_W-1:0]       timeout_ff;
   logic [dres_pkg::TICKS_W-1:0]       hold_ff;

   // supervisor state
   seq_state_type                      seq_ff, seq_in;
   dres_pkg::phase_type                phase_ff, phase_in;
   logic [3:0]                         sub_ff, sub_in;
   logic [3:0]                         wait_ff, wait_in;
   logic [dres_pkg::TIMER_W-1:0]       timer_ff, timer_in;
   logic [15:0]                        status_ff [dres_pkg::MAX_DRIVES];

   // latched transaction
   logic                               op_ff;
   logic [10:0]                        id_ff;
   logic [15:0]                        sw_ff;

   // decode
   logic [2:0]                         cnt;
   dres_pkg::drive_mask_type           dvalid;
   dres_pkg::drive_mask_type           fault_vec;
   dres_pkg::drive_mask_type           open_vec;
   dres_pkg::drive_mask_type           lost_vec;
   dres_pkg::drive_mask_type           hit_vec;
   dres_pkg::drive_idx_type            hit_drive;
   logic                               hit;
   logic [3:0]                         limit;
   logic [dres_pkg::TIMER_W-1:0]       timer_inc;
   logic [dres_pkg::TICKS_W-1:0]       period;
   logic                               accept;
   logic                               go;
   logic [3:0]                         sub_v;
   logic [3:0]                         wait_v;
   logic [1:0]                         slot;

   dres_pkg::emit_cmd_type             ecmd;
   logic                               emit_start;
   logic                               emit_busy;
   logic                               div_start;
   logic                               div_busy;
   logic                               rem_zero;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (seq_ff == S_IDLE);
   assign timer_inc = timer_ff + 1'b1;
   assign period = (retry_ff == '0) ? dres_pkg::TICKS_W'(1) : retry_ff;
   assign div_start = accept && (req_tuser == dres_pkg::OP_TICK) &&
                      (phase_ff == dres_pkg::PH_WAIT);
   assign emit_start = (seq_ff == S_DECIDE);

   // drive count clamp and per-drive status flags
   always_comb begin
      if (motor_count_ff == 3'd0) begin
         cnt = 3'd1;
      end else if (motor_count_ff > 3'(dres_pkg::MAX_DRIVES)) begin
         cnt = 3'(dres_pkg::MAX_DRIVES);
      end else begin
         cnt = motor_count_ff;
      end
      limit = 4'({cnt, 1'b0}) + 4'(cnt) + 4'd2;
      for (int d = 0; d < dres_pkg::MAX_DRIVES; d++) begin
         dvalid[d] = (3'(d) < cnt);
         fault_vec[d] = dvalid[d] && status_ff[d][dres_pkg::SW_FAULT_BIT];
         open_vec[d] = (status_ff[d] & dres_pkg::SW_OPEN_MASK) == dres_pkg::SW_OPEN_VALUE;
         lost_vec[d] = dvalid[d] && !status_ff[d][dres_pkg::SW_ENABLED_BIT];
         hit_vec[d] = dvalid[d] && (node_id_ff[d] == id_ff[6:0]);
      end
   end

   // lowest-numbered drive that owns the received node id
   always_comb begin
      hit_drive = '0;
      for (int d = dres_pkg::MAX_DRIVES - 1; d >= 0; d--) begin
         if (hit_vec[d]) begin
            hit_drive = 2'(d);
         end
      end
      hit = (id_ff[10:7] == dres_pkg::TPDO_ID_HIGH) && (id_ff[6:0] != 7'd0) &&
            (hit_vec != '0);
   end

   // supervisor step for one tick
   always_comb begin
      phase_in = phase_ff;
      sub_in = sub_ff;
      wait_in = wait_ff;
      timer_in = timer_ff;
      ecmd.kind = dres_pkg::EK_NONE;
      ecmd.mask = '0;
      ecmd.cmd = '0;
      go = 1'b1;
      sub_v = sub_ff;
      wait_v = wait_ff;
      slot = dres_pkg::sub_slot(sub_ff);
      if (op_ff == dres_pkg::OP_TICK) begin
         case (phase_ff)
            dres_pkg::PH_INIT: phase_in = dres_pkg::PH_SYSCHECK;
            dres_pkg::PH_SYSCHECK: phase_in = dres_pkg::PH_INITMOTOR;
            dres_pkg::PH_INITMOTOR: begin
               // gap countdown, then the next command of the sequence
               if (sub_ff == 4'd0) begin
                  sub_v = 4'd1;
                  wait_v = 4'd0;
               end else if (wait_ff != 4'd0) begin
                  wait_v = wait_ff - 1'b1;
                  go = (wait_v == 4'd0);
               end
               sub_in = sub_v;
               wait_in = wait_v;
               slot = dres_pkg::sub_slot(sub_v);
               if (go) begin
                  if (sub_v == 4'd1) begin
                     ecmd.kind = dres_pkg::EK_MODE;
                     ecmd.mask = dvalid;
                     wait_in = dres_pkg::CMD_GAP_TICKS;
                     sub_in = 4'd2;
                  end else if (sub_v >= 4'd2 && sub_v < limit) begin
                     ecmd.kind = dres_pkg::EK_CTRL;
                     ecmd.mask = dres_pkg::drive_mask_type'(1) << dres_pkg::sub_drive(sub_v);
                     case (slot)
                        2'd0:    ecmd.cmd = dres_pkg::CW_SHUTDOWN;
                        2'd1:    ecmd.cmd = dres_pkg::CW_SWITCH_ON;
                        default: ecmd.cmd = dres_pkg::CW_ENABLE_OP;
                     endcase
                     wait_in = (slot == 2'd2) ? dres_pkg::ENABLE_GAP_TICKS
                                              : dres_pkg::CMD_GAP_TICKS;
                     sub_in = sub_v + 1'b1;
                  end else begin
                     sub_in = 4'd0;
                     phase_in = dres_pkg::PH_CHECK;
                  end
               end
            end
            dres_pkg::PH_CHECK: begin
               if (fault_vec != '0) begin
                  phase_in = dres_pkg::PH_FAULT;
               end else begin
                  phase_in = dres_pkg::PH_WAIT;
                  timer_in = '0;
               end
            end
            dres_pkg::PH_WAIT: begin
               // re-enable bursts on the retry period, error past the timeout
               timer_in = timer_inc;
               if (fault_vec != '0) begin
                  phase_in = dres_pkg::PH_FAULT;
               end else if ((open_vec & dvalid) == dvalid) begin
                  phase_in = dres_pkg::PH_BASE;
               end else begin
                  if (rem_zero) begin
                     ecmd.kind = dres_pkg::EK_BURST;
                     ecmd.mask = dvalid & ~open_vec;
                  end
                  if (timer_inc > {1'b0, timeout_ff}) begin
                     phase_in = dres_pkg::PH_ERROR;
                  end
               end
            end
            dres_pkg::PH_BASE: begin
               if (lost_vec != '0) begin
                  ecmd.kind = dres_pkg::EK_BURST;
                  ecmd.mask = dvalid;
                  phase_in = dres_pkg::PH_WAIT;
                  timer_in = '0;
               end
            end
            dres_pkg::PH_FAULT: begin
               phase_in = dres_pkg::PH_CLEAR;
               timer_in = '0;
            end
            dres_pkg::PH_CLEAR: begin
               timer_in = timer_inc;
               if (timer_inc == dres_pkg::TIMER_W'(1)) begin
                  ecmd.kind = dres_pkg::EK_CLEAR;
                  ecmd.mask = dvalid;
               end
               if (timer_inc > {1'b0, hold_ff}) begin
                  phase_in = dres_pkg::PH_INITMOTOR;
               end
            end
            default: begin
            end
         endcase
      end
      ecmd.state = phase_in;
   end

   // sequencer
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         S_IDLE: begin
            if (accept) begin
               seq_in = div_start ? S_DIVIDE : S_DECIDE;
            end
         end
         S_DIVIDE: begin
            if (!div_busy) begin
               seq_in = S_DECIDE;
            end
         end
         S_DECIDE: seq_in = S_EMIT;
         S_EMIT: begin
            if (!emit_busy) begin
               seq_in = S_IDLE;
            end
         end
         default: seq_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE;
         phase_ff <= dres_pkg::PH_INIT;
         sub_ff <= '0;
         wait_ff <= '0;
         timer_ff <= '0;
      end else begin
         seq_ff <= seq_in;
         if (seq_ff == S_DECIDE) begin
            phase_ff <= phase_in;
            sub_ff <= sub_in;
            wait_ff <= wait_in;
            timer_ff <= timer_in;
         end
      end
   end

   // statusword store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < dres_pkg::MAX_DRIVES; d++) begin
            status_ff[d] <= '0;
         end
      end else if (seq_ff == S_DECIDE && op_ff == dres_pkg::OP_FRAME && hit) begin
         status_ff[hit_drive] <= sw_ff;
      end
   end

   // latch the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_tuser;
         id_ff <= req_tdata[10:0];
         sw_ff <= req_tdata[58:43];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_count_ff <= 3'd2;
         node_id_ff[0] <= 7'd1;
         node_id_ff[1] <= 7'd2;
         node_id_ff[2] <= 7'd3;
         node_id_ff[3] <= 7'd4;
         retry_ff <= 10'd50;
         timeout_ff <= 10'd250;
         hold_ff <= 10'd100;
      end else if (csr_we) begin
         case (csr_index)
            dres_pkg::CSR_MOTOR_COUNT:    motor_count_ff <= csr_wdata[2:0];
            dres_pkg::CSR_NODE_ID_A:      node_id_ff[0] <= csr_wdata[6:0];
            dres_pkg::CSR_NODE_ID_B:      node_id_ff[1] <= csr_wdata[6:0];
            dres_pkg::CSR_NODE_ID_C:      node_id_ff[2] <= csr_wdata[6:0];
            dres_pkg::CSR_NODE_ID_D:      node_id_ff[3] <= csr_wdata[6:0];
            dres_pkg::CSR_RETRY_PERIOD:   retry_ff <= csr_wdata;
            dres_pkg::CSR_ENABLE_TIMEOUT: timeout_ff <= csr_wdata;
            dres_pkg::CSR_FAULT_HOLD:     hold_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // retry period remainder
   dres_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (timer_inc),
      .divisor  (period),
      .busy     (div_busy),
      .rem_zero (rem_zero)
   );

   // frame run output
   dres_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .start      (emit_start),
      .cmd        (ecmd),
      .node_id    (node_id_ff),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/dres_rem_unit.sv]
`timescale 1ns / 1ps
// dres_rem_unit: iterative shift-subtract remainder, one quotient bit per cycle
// depends on dres_pkg for widths

module dres_rem_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dres_pkg::TIMER_W-1:0]      dividend,
   input  logic [dres_pkg::TICKS_W-1:0]      divisor,
   output logic                              busy,
   output logic                              rem_zero
);

   localparam int unsigned STEPS = dres_pkg::TIMER_W;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic [dres_pkg::TIMER_W-1:0] num_ff, num_in;
   logic [dres_pkg::TICKS_W-1:0] rem_ff, rem_in;
   logic [dres_pkg::TICKS_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         busy_ff, busy_in;
   logic [dres_pkg::TICKS_W:0]   trial;
   logic [dres_pkg::TICKS_W:0]   diff;

   // one restoring step per cycle
   always_comb begin
      trial = {rem_ff, num_ff[dres_pkg::TIMER_W-1]};
      diff = trial - {1'b0, div_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         div_in = divisor;
         count_in = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[dres_pkg::TIMER_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[dres_pkg::TICKS_W-1:0];
         end else begin
            rem_in = trial[dres_pkg::TICKS_W-1:0];
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

[rtl/dres_emitter.sv]
`timescale 1ns / 1ps
// dres_emitter: walks a run of sdo frames into the result register, one per cycle
// while rsp_tready is high; depends on dres_pkg for run descriptor, frame constants

module dres_emitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  dres_pkg::emit_cmd_type            cmd,
   input  dres_pkg::node_ids_type            node_id,
   output logic                              busy,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fields from bit 0: tx_valid, tx_id[10:0], tx_data[63:0], control_state[3:0]
   output logic [dres_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   dres_pkg::emit_kind_type  kind_ff;
   dres_pkg::drive_mask_type mask_ff;
   logic [1:0]               slot_ff;
   logic [7:0]               cmd_ff;
   dres_pkg::phase_type      state_ff;
   logic                     active_ff;

   logic                     out_valid_ff;
   logic                     tx_valid_ff;
   logic [10:0]              tx_id_ff;
   logic [63:0]              tx_data_ff;
   logic [3:0]               cstate_ff;
   logic                     last_ff;

   dres_pkg::drive_idx_type  drive;
   dres_pkg::drive_mask_type mask_rest;
   logic                     drive_done;
   logic                     frame_last;
   logic                     load;
   logic                     fr_valid;
   logic [10:0]              fr_id;
   logic [63:0]              fr_data;

   // pick the current drive and frame
   always_comb begin
      drive = '0;
      for (int i = dres_pkg::MAX_DRIVES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            drive = 2'(i);
         end
      end
      mask_rest = mask_ff & (mask_ff - 1'b1);
      if (kind_ff == dres_pkg::EK_MODE || kind_ff == dres_pkg::EK_CTRL) begin
         drive_done = 1'b1;
      end else begin
         drive_done = (slot_ff == 2'd2);
      end
      fr_valid = (kind_ff != dres_pkg::EK_NONE) && (mask_ff != '0);
      frame_last = !fr_valid || (drive_done && mask_rest == '0);
      case (kind_ff)
         dres_pkg::EK_MODE: fr_data = dres_pkg::MODE_FRAME;
         dres_pkg::EK_CTRL: fr_data = dres_pkg::ctrl_frame(cmd_ff);
         dres_pkg::EK_BURST: begin
            case (slot_ff)
               2'd0:    fr_data = dres_pkg::ctrl_frame(dres_pkg::CW_SHUTDOWN);
               2'd1:    fr_data = dres_pkg::ctrl_frame(dres_pkg::CW_SWITCH_ON);
               default: fr_data = dres_pkg::ctrl_frame(dres_pkg::CW_ENABLE_OP);
            endcase
         end
         dres_pkg::EK_CLEAR: begin
            case (slot_ff)
               2'd0:    fr_data = dres_pkg::ctrl_frame(dres_pkg::CW_FAULT_RESET);
               2'd1:    fr_data = dres_pkg::ctrl_frame(dres_pkg::CW_SHUTDOWN);
               default: fr_data = dres_pkg::CLEAR_AUX_FRAME;
            endcase
         end
         default: fr_data = '0;
      endcase
      if (fr_valid) begin
         fr_id = dres_pkg::SDO_ID_BASE + {4'b0, node_id[drive]};
      end else begin
         fr_id = '0;
         fr_data = '0;
      end
      load = active_ff && (!out_valid_ff || rsp_tready);
   end

   // run control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         kind_ff <= dres_pkg::EK_NONE;
         mask_ff <= '0;
         slot_ff <= '0;
      end else if (start) begin
         active_ff <= 1'b1;
         kind_ff <= cmd.kind;
         mask_ff <= cmd.mask;
         slot_ff <= '0;
      end else if (load) begin
         if (frame_last) begin
            active_ff <= 1'b0;
         end else if (drive_done) begin
            mask_ff <= mask_rest;
            slot_ff <= '0;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= cmd.cmd;
         state_ff <= cmd.state;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tx_valid_ff <= fr_valid;
         tx_id_ff <= fr_id;
         tx_data_ff <= fr_data;
         cstate_ff <= state_ff;
         last_ff <= frame_last;
      end
   end

   assign busy = active_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {cstate_ff, tx_data_ff, tx_id_ff, tx_valid_ff};
   assign rsp_tlast = last_ff;

endmodule
